@@ rtl/core/ptns_pkg.sv @@
`default_nettype none

package ptns_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POINT_W     = 32;
  localparam int SQ_W        = 32;
  localparam int DIST_W      = SQ_W + 1;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_FIND   = 3'd1,
    CMD_READ   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_DUP    = 3'd4,
    CMD_REMOVE = 3'd5
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OOB   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  // squared-difference stage output, one entry per cycle
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic [POINT_W-1:0] point;
    logic [SQ_W-1:0]    sq_x;
    logic [SQ_W-1:0]    sq_y;
  } dist_t;

endpackage

`default_nettype wire

@@ rtl/core/ptns_ram.sv @@
`default_nettype none

module ptns_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/ptns_dist.sv @@
`default_nettype none

module ptns_dist (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [ptns_pkg::IDX_W-1:0]     in_idx,
  input  wire logic [ptns_pkg::POINT_W-1:0]   in_point,
  input  wire logic [15:0]                    qx,
  input  wire logic [15:0]                    qy,
  output ptns_pkg::dist_t                     dres
);

  import ptns_pkg::*;

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] px2;
  logic signed [33:0] py2;

  assign dx  = $signed({qx[15], qx}) - $signed({in_point[15], in_point[15:0]});
  assign dy  = $signed({qy[15], qy}) - $signed({in_point[31], in_point[31:16]});
  assign px2 = dx * dx;
  assign py2 = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dres.valid <= 1'b0;
    end else begin
      dres.valid <= in_valid;
    end
    dres.idx   <= in_idx;
    dres.point <= in_point;
    // a square of a 17-bit difference never exceeds 32 bits
    dres.sq_x  <= px2[SQ_W-1:0];
    dres.sq_y  <= py2[SQ_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/point_table_nearest_search.sv @@
`default_nettype none

// Ordered table of up to 64 signed 16-bit 2-D points in a single-port-read,
// single-port-write RAM, with a stored count and a selected index. A command
// is taken when start is high and busy is low; its one result appears for a
// single cycle with done high and must be captured then, since the block
// cannot be stalled. Add, and commands that fail their checks (full, empty,
// selection out of range) or are unused, answer in the cycle after accept.
// Find, duplicate check and remove matching walk the whole table, read
// selected walks one entry and delete selected walks from the selection to
// the end. Each entry read passes the RAM output register, for find then
// the distance stage register, and done is registered once the last has.
// Duplicate check and remove matching on an empty table walk nothing and
// answer after one pass through the scan state. The RAM read port reads one
// entry per cycle. busy is low again in the cycle done is high. No
// clearing pass after reset.
module point_table_nearest_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command,
  input  wire logic [15:0] point_x,
  input  wire logic [15:0] point_y,
  output logic             done,
  output logic [1:0]       status,
  output logic             found,
  output logic [15:0]      result_x,
  output logic [15:0]      result_y,
  output logic [5:0]       result_index,
  output logic [6:0]       entry_count,
  output logic             repath
);

  import ptns_pkg::*;

  state_t             state;
  cmd_t               op;
  logic [15:0]        qx;
  logic [15:0]        qy;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   sel;
  logic [CNT_W-1:0]   ridx;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   wptr;
  logic               v1;
  logic [IDX_W-1:0]   i1;
  logic [POINT_W-1:0] rdata;
  dist_t              dres;

  logic               first;
  logic [DIST_W-1:0]  best_d;
  logic [IDX_W-1:0]   best_i;
  logic [POINT_W-1:0] best_pt;
  logic               acc_found;
  logic               acc_repath;
  logic [POINT_W-1:0] acc_pt;

  logic               accept;
  logic               issue;
  logic               match;
  logic               drop;
  logic               keep_wr;
  logic               add_wr;
  logic               scan_end;
  logic [DIST_W-1:0]  dsum;
  logic [CNT_W-1:0]   sel_ext;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [POINT_W-1:0] wdata;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign sel_ext  = CNT_W'(sel);
  assign issue    = (state == S_SCAN) && (ridx < lim);
  assign match    = (rdata == {qy, qx});
  assign drop     = ((op == CMD_DELETE) && (i1 == sel)) || ((op == CMD_REMOVE) && match);
  assign keep_wr  = v1 && ((op == CMD_DELETE) || (op == CMD_REMOVE)) && !drop;
  assign add_wr   = accept && (cmd_t'(command) == CMD_ADD) && (cnt < CNT_W'(TABLE_DEPTH));
  assign scan_end = (state == S_SCAN) && !issue && !v1 && !dres.valid;
  assign dsum     = {1'b0, dres.sq_x} + {1'b0, dres.sq_y};

  // compaction writes land at wptr, always below the address being read
  always_comb begin
    we    = add_wr || keep_wr;
    waddr = add_wr ? cnt[IDX_W-1:0] : wptr[IDX_W-1:0];
    wdata = add_wr ? {point_y, point_x} : rdata;
  end

  ptns_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W),
    .DW    (POINT_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ridx[IDX_W-1:0]),
    .rdata (rdata)
  );

  ptns_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1 && (op == CMD_FIND)),
    .in_idx   (i1),
    .in_point (rdata),
    .qx       (qx),
    .qy       (qy),
    .dres     (dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      sel   <= '0;
      v1    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= issue;
      i1   <= ridx[IDX_W-1:0];
      if (issue) begin
        ridx <= ridx + CNT_W'(1);
      end

      if (accept) begin
        op       <= cmd_t'(command);
        qx       <= point_x;
        qy       <= point_y;
        status   <= ST_OK;
        found    <= 1'b0;
        result_x <= '0;
        result_y <= '0;
        repath   <= 1'b0;
        result_index <= 6'(sel);
        entry_count  <= 7'(cnt);
        first      <= 1'b1;
        acc_found  <= 1'b0;
        acc_repath <= 1'b0;
        ridx <= '0;
        lim  <= cnt;
        wptr <= '0;
        case (cmd_t'(command))
          CMD_ADD: begin
            done <= 1'b1;
            if (cnt < CNT_W'(TABLE_DEPTH)) begin
              cnt         <= cnt + CNT_W'(1);
              entry_count <= 7'(cnt + CNT_W'(1));
            end else begin
              status <= ST_FULL;
            end
          end
          CMD_FIND: begin
            if (cnt == '0) begin
              done   <= 1'b1;
              status <= ST_EMPTY;
            end else begin
              state <= S_SCAN;
            end
          end
          CMD_READ, CMD_DELETE: begin
            if (cnt == '0) begin
              done   <= 1'b1;
              status <= ST_EMPTY;
            end else if (sel_ext >= cnt) begin
              done   <= 1'b1;
              status <= ST_OOB;
            end else begin
              state <= S_SCAN;
              ridx  <= sel_ext;
              wptr  <= sel_ext;
              if (cmd_t'(command) == CMD_READ) begin
                lim <= sel_ext + CNT_W'(1);
              end
            end
          end
          CMD_DUP, CMD_REMOVE: begin
            state <= S_SCAN;
          end
          default: begin
            done <= 1'b1;
          end
        endcase
      end

      // entry data available this cycle
      if (v1) begin
        if ((op == CMD_READ) || ((op == CMD_DELETE) && (i1 == sel))) begin
          acc_pt <= rdata;
        end
        if ((op == CMD_DUP) && match) begin
          acc_found <= 1'b1;
        end
        if ((op == CMD_REMOVE) && match) begin
          acc_found <= 1'b1;
          if (wptr == sel_ext) begin
            acc_repath <= 1'b1;
          end
        end
        if (keep_wr) begin
          wptr <= wptr + CNT_W'(1);
        end
      end

      // strict compare keeps the lowest index on a tie
      if (dres.valid) begin
        first <= 1'b0;
        if (first || (dsum < best_d)) begin
          best_d  <= dsum;
          best_i  <= dres.idx;
          best_pt <= dres.point;
        end
      end

      if (scan_end) begin
        state    <= S_IDLE;
        done     <= 1'b1;
        status   <= ST_OK;
        found    <= acc_found;
        repath   <= acc_repath;
        result_x <= '0;
        result_y <= '0;
        result_index <= 6'(sel);
        entry_count  <= 7'(cnt);
        case (op)
          CMD_FIND: begin
            found        <= 1'b1;
            sel          <= best_i;
            result_index <= 6'(best_i);
            result_x     <= best_pt[15:0];
            result_y     <= best_pt[31:16];
          end
          CMD_READ: begin
            result_x <= acc_pt[15:0];
            result_y <= acc_pt[31:16];
          end
          CMD_DELETE: begin
            result_x    <= acc_pt[15:0];
            result_y    <= acc_pt[31:16];
            cnt         <= wptr;
            entry_count <= 7'(wptr);
          end
          CMD_REMOVE: begin
            cnt         <= wptr;
            entry_count <= 7'(wptr);
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while a scan is running");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_wptr_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (wptr <= ridx))
    else $error("compaction write pointer passed read pointer");

  a_full_add: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == CMD_ADD) && (cnt == CNT_W'(TABLE_DEPTH)))
      |=> (done && (status == ST_FULL) && (cnt == CNT_W'(TABLE_DEPTH))))
    else $error("add to full table not rejected");

  a_scan_no_write_add: assert property (@(posedge clk) disable iff (rst)
    add_wr |-> !keep_wr)
    else $error("add write collides with compaction write");
`endif

endmodule

`default_nettype wire
